// ===== hdl/mwwc_pkg.sv =====
// Shared widths, register indexes and limits of the mostly white window counter.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package mwwc_pkg;

  localparam int PIXEL_W      = 8;
  localparam int TALLY_W      = 17;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 11;

  localparam int IMG_WIDTH_W  = 7;
  localparam int IMG_HEIGHT_W = 11;
  localparam int WIN_SIZE_W   = 4;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_WINDOW = 8;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int ROW_W          = $clog2(HEIGHT_LIMIT);

  localparam logic [IMG_WIDTH_W-1:0]  RST_IMG_WIDTH  = 7'd5;
  localparam logic [IMG_HEIGHT_W-1:0] RST_IMG_HEIGHT = 11'd4;
  localparam logic [WIN_SIZE_W-1:0]   RST_WIN_SIZE   = 4'd2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/mostly_white_window_counter_top.sv =====
// Mostly white window counter: column history memory, row ring and frame tally.
// Depends on mwwc_pkg.
`default_nettype none

// Takes pixels in raster order and, after each frame, offers the registered
// number of k-by-k windows whose white (zero) pixels exceed floor(k*k/2). The
// rate is one pixel a cycle while pixel_ready is high, set by the single
// read-modify-write of the column history memory per pixel: the read is issued
// as the pixel is taken, the write-back as it leaves stage 1, and a bypass
// register covers a one-pixel-wide frame. pixel_ready drops only in reset or
// while a frame result waits on the output and the next frame's last pixel is
// already in the second stage. A write to any register index 0..2 restarts the
// frame; the column history memory needs no clearing after reset.
module mostly_white_window_counter_top
  import mwwc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   pixel_valid,
  output logic                        pixel_ready,
  input  wire logic [PIXEL_W-1:0]     pixel,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic [TALLY_W-1:0]          mostly_white_windows
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int HW   = ROW_W + 1;

  // configuration registers
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [WIN_SIZE_W-1:0]   window_size;
  logic                    restart;

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [KW-1:0] eff_k;

  // stage 0: raster position
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [SW-1:0]    slot;
  logic             col_last;
  logic             row_last;
  logic             accept;

  // stage 1
  typedef struct packed {
    logic          col_zero;
    logic          count_en;
    logic          last;
    logic          white;
    logic          fwd;
    logic [KW-1:0] depth;
    logic [SW-1:0] slot;
    logic [CW-1:0] col;
  } s1_t;

  logic                  s1_valid;
  s1_t                   s1;
  s1_t                   s1_next;
  logic                  s1_adv;
  logic [MAX_WINDOW-1:0] mem_q;
  logic [MAX_WINDOW-1:0] fwd_data;
  logic [MAX_WINDOW-1:0] prev_hist;
  logic [MAX_WINDOW-1:0] hist_mask;
  logic [MAX_WINDOW-1:0] hist;
  logic [KW-1:0]         ccount;
  logic [KW-1:0]         ring_old;
  logic [SUMW-1:0]       hsum;
  logic [SUMW-1:0]       hsum_next;
  logic [SUMW-1:0]       kk_half;
  logic [TALLY_W-1:0]    tally;
  logic [TALLY_W-1:0]    tally_next;

  logic [KW-1:0]         ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] col_hist [MAX_WIDTH];

  function automatic logic [KW-1:0] popcount(input logic [MAX_WINDOW-1:0] v);
    logic [KW-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      n = n + KW'(v[i]);
    end
    return n;
  endfunction

  // effective configuration, saturated to the supported ranges
  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(image_height) > HEIGHT_LIMIT) begin
      eff_h = HW'(HEIGHT_LIMIT);
    end else begin
      eff_h = HW'(image_height);
    end
    if (window_size == '0) begin
      eff_k = KW'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      eff_k = KW'(MAX_WINDOW);
    end else begin
      eff_k = KW'(window_size);
    end
  end

  assign restart = cfg_write && (cfg_index == REG_IMAGE_WIDTH ||
                                 cfg_index == REG_IMAGE_HEIGHT ||
                                 cfg_index == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMG_WIDTH;
      image_height <= RST_IMG_HEIGHT;
      window_size  <= RST_WIN_SIZE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WIN_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv      = !(s1.last && result_valid && !result_ready);
  assign pixel_ready = !rst && (!s1_valid || s1_adv);
  assign accept      = pixel_valid && pixel_ready;

  assign col_last = (EW'(col) + EW'(1)) >= eff_w;
  assign row_last = (HW'(row) + HW'(1)) >= eff_h;

  always_comb begin
    s1_next.col_zero = (col == '0);
    s1_next.count_en = (int'(row) + 1 >= int'(eff_k)) && (int'(col) + 1 >= int'(eff_k));
    s1_next.last     = col_last && row_last;
    s1_next.white    = (pixel == '0);
    // the same column is rewritten by stage 1 this cycle: take its new value
    s1_next.fwd      = s1_valid && s1_adv && (s1.col == col);
    // rows above the frame top are masked off
    s1_next.depth    = (int'(row) + 1 >= int'(eff_k)) ? eff_k : KW'(int'(row) + 1);
    s1_next.slot     = slot;
    s1_next.col      = col;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (col_last) begin
        col  <= '0;
        slot <= '0;
        row  <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col  <= col + CW'(1);
        slot <= (int'(slot) + 1 >= int'(eff_k)) ? '0 : slot + SW'(1);
      end
    end
  end

  // column history memory: read on accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= col_hist[col];
    end
    if (s1_valid && s1_adv) begin
      col_hist[s1.col] <= hist;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= s1_next;
      fwd_data <= hist;
    end
  end

  always_comb begin
    prev_hist = s1.fwd ? fwd_data : mem_q;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      hist_mask[i] = (i < int'(s1.depth));
    end
    hist      = ((prev_hist << 1) | MAX_WINDOW'(s1.white)) & hist_mask;
    ccount    = popcount(hist);
    ring_old  = s1.col_zero ? '0 : ring[s1.slot];
    hsum_next = (s1.col_zero ? '0 : hsum) + SUMW'(ccount) - SUMW'(ring_old);
    kk_half   = SUMW'((int'(eff_k) * int'(eff_k)) >> 1);
    tally_next = tally;
    if (s1.count_en && hsum_next > kk_half && tally != TALLY_MAX) begin
      tally_next = tally + TALLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
      hsum     <= '0;
      tally    <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        hsum  <= hsum_next;
        tally <= s1.last ? '0 : tally_next;
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if (SW'(i) == s1.slot) begin
            ring[i] <= ccount;
          end else if (s1.col_zero) begin
            ring[i] <= '0;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_valid && s1_adv && s1.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && s1.last) begin
      mostly_white_windows <= tally_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mwwc_checker.sv =====
// Port-level checks for the mostly white window counter, bound to its top level.
// Depends on mwwc_pkg and mostly_white_window_counter_top.
`default_nettype none

module mwwc_checker
  import mwwc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               pixel_valid,
  input wire logic               pixel_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic [TALLY_W-1:0] mostly_white_windows
);

  // a waiting result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(mostly_white_windows))
    else $error("result changed or dropped while stalled");

  // input only backs up behind a pending result
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("pixel_ready low with empty output");

  // a new result follows an accepted item
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_valid && pixel_ready, 2))
    else $error("result without a preceding item");

  // no item taken during reset, output empty once reset has been seen
  a_reset_clear: assert property (@(posedge clk)
    rst |-> !pixel_ready ##1 !result_valid)
    else $error("outputs not quiet after reset");

endmodule

bind mostly_white_window_counter_top mwwc_checker u_mwwc_checker (.*);

`default_nettype wire
